>>> hw/rtl/vtse_pkg.sv
// ----------------------------------------------------------------------------
// vtse_pkg
// Shared types, constants and font lookups of the VFD text segment encoder.
// ----------------------------------------------------------------------------
package vtse_pkg;

	localparam int DIGIT_COUNT = 6;
	localparam int TEXT_WORDS  = 5;
	localparam int MAX_CHARS   = 9;
	localparam int FRAME_BYTES = 3 * DIGIT_COUNT;
	localparam int WORD_IDX_W  = $clog2(DIGIT_COUNT);
	localparam int TEXT_IDX_W  = 3;

	localparam logic [23:0] COLON_WORD3 = 24'h080000;
	localparam logic [23:0] COLON_WORD1 = 24'h001000;
	localparam logic [23:0] ICON_WORD4  = 24'h020000;

	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	typedef struct packed {
		logic [7:0] char_0;
		logic [7:0] char_1;
		logic [7:0] char_2;
		logic [7:0] char_3;
		logic [7:0] char_4;
		logic [7:0] char_5;
		logic [7:0] char_6;
		logic [7:0] char_7;
		logic [7:0] char_8;
		logic [3:0] text_length;
		logic       colon_on;
	} text_item_t;

	typedef struct packed {
		logic [7:0] segment_byte;
		logic [5:0] byte_index;
		logic       last_byte;
	} seg_item_t;

	typedef logic [TEXT_WORDS-1:0][23:0] text_words_t;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} q_status_t;

	function automatic logic [23:0] font_one(input logic [7:0] c);
		logic [23:0] g;
		g = 24'h000000;
		if (c == CHAR_DASH) begin
			g = 24'h080000;
		end else if (c >= CHAR_ZERO && c <= CHAR_COLON) begin
			unique case (c[3:0])
				4'h0:    g = 24'h770000;
				4'h1:    g = 24'h240000;
				4'h2:    g = 24'h6b0000;
				4'h3:    g = 24'h6d0000;
				4'h4:    g = 24'h3c0000;
				4'h5:    g = 24'h5d0000;
				4'h6:    g = 24'h5f0000;
				4'h7:    g = 24'h640000;
				4'h8:    g = 24'h7f0000;
				4'h9:    g = 24'h7d0000;
				default: g = 24'h000100;
			endcase
		end
		return g;
	endfunction

	// colon and dash share one glyph in this font
	function automatic logic [23:0] font_two(input logic [7:0] c);
		logic [23:0] g;
		g = 24'h000000;
		if (c == CHAR_DASH) begin
			g = 24'h001000;
		end else if (c >= CHAR_ZERO && c <= CHAR_COLON) begin
			unique case (c[3:0])
				4'h0:    g = 24'h00ee00;
				4'h1:    g = 24'h004800;
				4'h2:    g = 24'h00d600;
				4'h3:    g = 24'h00da00;
				4'h4:    g = 24'h007800;
				4'h5:    g = 24'h00ba00;
				4'h6:    g = 24'h00be00;
				4'h7:    g = 24'h00c800;
				4'h8:    g = 24'h00fe00;
				4'h9:    g = 24'h00fa00;
				default: g = 24'h001000;
			endcase
		end
		return g;
	endfunction

endpackage

>>> hw/rtl/vtse_front.sv
// ----------------------------------------------------------------------------
// vtse_front
// Accepts a text word, maps each character to its glyph and packs the five
// text digit words into a register stage ahead of the frame queue.
// ----------------------------------------------------------------------------
module vtse_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_stall,
	input  vtse_pkg::text_item_t  text,
	output logic                  push,
	output vtse_pkg::text_words_t push_words,
	input  vtse_pkg::q_status_t   q_stat
);
	import vtse_pkg::*;

	logic        valid_s1;
	text_words_t words_s1;
	logic        advance;
	logic [3:0]  len_sat;
	logic [MAX_CHARS-1:0][7:0] chars;
	text_words_t words_d;

	assign advance    = !valid_s1 || q_stat.not_full;
	assign text_stall = !advance;
	assign push       = valid_s1 && q_stat.not_full;
	assign push_words = words_s1;

	always_comb begin
		chars = {text.char_8, text.char_7, text.char_6, text.char_5, text.char_4,
		         text.char_3, text.char_2, text.char_1, text.char_0};
		len_sat = (text.text_length > 4'(MAX_CHARS)) ? 4'(MAX_CHARS) : text.text_length;
		words_d = '0;
		for (int k = 0; k < MAX_CHARS; k++) begin
			if (4'(k) < len_sat) begin
				// even positions below eight take font one, the rest font two
				if (k != 8 && (k % 2) == 0) begin
					words_d[k/2] = words_d[k/2] | font_one(chars[k]);
				end else begin
					words_d[k/2] = words_d[k/2] | font_two(chars[k]);
				end
			end
		end
		if (text.colon_on) begin
			words_d[3] = words_d[3] | COLON_WORD3;
			words_d[1] = words_d[1] | COLON_WORD1;
		end
		words_d[4] = words_d[4] | ICON_WORD4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && text_valid) begin
			words_s1 <= words_d;
		end
	end

endmodule

>>> hw/rtl/vtse_queue.sv
// ----------------------------------------------------------------------------
// vtse_queue
// Two-entry queue of packed text words between the front and the serialiser.
// ----------------------------------------------------------------------------
module vtse_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vtse_pkg::text_words_t push_words,
	input  logic                  pop,
	output vtse_pkg::text_words_t pop_words,
	output vtse_pkg::q_status_t   q_stat
);
	import vtse_pkg::*;

	text_words_t entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign pop_words        = entry_q[rd_ptr_q];
	assign q_stat.not_empty = (count_q != 2'd0);
	assign q_stat.not_full  = (count_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_words;
		end
	end

endmodule

>>> hw/rtl/vtse_back.sv
// ----------------------------------------------------------------------------
// vtse_back
// Serialises one frame of digit words into bytes, high byte first, through
// an output register. Digit words past the text words are sent as zero.
// ----------------------------------------------------------------------------
module vtse_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vtse_pkg::q_status_t   q_stat,
	input  vtse_pkg::text_words_t pop_words,
	output logic                  pop,
	output logic                  seg_valid,
	input  logic                  seg_stall,
	output vtse_pkg::seg_item_t   seg
);
	import vtse_pkg::*;

	text_words_t           frame_q;
	logic                  busy_q;
	logic [5:0]            cnt_q;
	logic [WORD_IDX_W-1:0] word_q;
	logic [1:0]            sub_q;
	logic                  out_valid_q;
	seg_item_t             out_q;
	logic                  advance;
	logic                  last_now;
	logic [23:0]           cur_word;
	logic [7:0]            cur_byte;

	assign advance   = !out_valid_q || !seg_stall;
	assign last_now  = (cnt_q == 6'(FRAME_BYTES - 1));
	// load the next frame as the last byte of this one leaves
	assign pop       = advance && (!busy_q || last_now) && q_stat.not_empty;
	assign seg_valid = out_valid_q;
	assign seg       = out_q;

	always_comb begin
		cur_word = '0;
		if (word_q < WORD_IDX_W'(TEXT_WORDS)) begin
			cur_word = frame_q[word_q[TEXT_IDX_W-1:0]];
		end
		unique case (sub_q)
			2'd0:    cur_byte = cur_word[23:16];
			2'd1:    cur_byte = cur_word[15:8];
			default: cur_byte = cur_word[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			word_q      <= '0;
			sub_q       <= '0;
		end else if (advance) begin
			out_valid_q <= busy_q;
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				word_q <= '0;
				sub_q  <= '0;
			end else if (busy_q && last_now) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (sub_q == 2'd2) begin
					sub_q  <= 2'd0;
					word_q <= word_q + WORD_IDX_W'(1);
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= pop_words;
		end
		if (advance && busy_q) begin
			out_q.segment_byte <= cur_byte;
			out_q.byte_index   <= cnt_q;
			out_q.last_byte    <= last_now;
		end
	end

endmodule

>>> hw/rtl/vfd_text_segment_encoder_top.sv
// ----------------------------------------------------------------------------
// vfd_text_segment_encoder_top
// VFD text segment encoder: text word in, frame of segment bytes out.
// ----------------------------------------------------------------------------
// Each accepted text word yields a frame of 3*DIGIT_COUNT segment bytes (18 at
// the default of six digits), one byte per cycle while seg_stall is low,
// numbered in byte_index and closed by last_byte. The byte serialiser sets
// the rate: with back-to-back text words and no stall, a new frame's first
// byte follows the previous one's last byte directly. Glyph mapping takes one
// register stage and a two-entry queue holds further text words, so the input
// keeps accepting while a frame is still being sent, until the queue is full.
// ----------------------------------------------------------------------------
module vfd_text_segment_encoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_stall,
	input  vtse_pkg::text_item_t text,
	output logic                 seg_valid,
	input  logic                 seg_stall,
	output vtse_pkg::seg_item_t  seg
);
	import vtse_pkg::*;

	logic        push;
	logic        pop;
	text_words_t push_words;
	text_words_t pop_words;
	q_status_t   q_stat;

	vtse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.push       (push),
		.push_words (push_words),
		.q_stat     (q_stat)
	);

	vtse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_words (push_words),
		.pop        (pop),
		.pop_words  (pop_words),
		.q_stat     (q_stat)
	);

	vtse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_words (pop_words),
		.pop       (pop),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg)
	);

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_stat.not_full)
		else $error("push into full queue");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("pop from empty queue");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> (seg.last_byte == (seg.byte_index == 6'(FRAME_BYTES - 1))))
		else $error("last_byte out of step with byte_index");

	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && !seg_stall && !seg.last_byte) |=>
		(seg_valid && seg.byte_index == 6'($past(seg.byte_index) + 6'd1)))
		else $error("frame byte sequence broken");

endmodule
